[rtl/core/tqe_pkg.sv]
// types, constants and sizes shared by the timer queue expiry unit
package tqe_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_DUP  = 2'd2;

  localparam logic [15:0] MIN_DELAY_RST = 16'd100;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] timer_id;
    logic [47:0] deadline;
    logic [31:0] interval;
    logic [47:0] now;
  } in_word_t;

  typedef struct packed {
    logic        is_fire;
    logic [15:0] fired_id;
    logic [1:0]  status;
    logic        earliest_changed;
    logic        next_valid;
    logic [47:0] next_deadline;
    logic [47:0] next_delay;
    logic        last;
  } out_word_t;

  // ordering key: deadline first, id breaks ties
  typedef struct packed {
    logic [47:0] deadline;
    logic [15:0] timer_id;
  } key_t;

endpackage

[rtl/core/timer_queue_expiry_unit.sv]
// top level of the timer queue expiry unit: slot table, scan sequencer, output register
//
// channel | direction | handshake            | word
// --------+-----------+----------------------+------------------------------
// in      | input     | in_valid_i/in_stall_o | in_word_t (kind, id, times)
// out     | output    | out_valid_o/out_stall_i | out_word_t (fire or status)
// cfg     | input     | cfg_we_i             | cfg_wdata_i = min_delay_us
//
// every command walks the slot table one slot per cycle, with a post step after each
// pass to act on the pass result, sharing a single key comparator
// add/cancel: two passes plus output wait; unused kind: the status pass only
// tick, k fires: a pick pass per fire, a final pick pass, a status pass, output waits
// reset clears slot valid bits and the sequencer at once; no clearing pass
// in_stall_o stays high from acceptance until the status word is taken
module timer_queue_expiry_unit
  import tqe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o,
  input  logic      cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_POST, ST_FIRE, ST_STAT} state_e;
  typedef enum logic [1:0] {PS_ADD, PS_CANCEL, PS_PICK, PS_STAT} pass_e;

  // slot table
  logic              valid_q [SLOTS];
  logic [15:0]       id_q    [SLOTS];
  logic [47:0]       dl_q    [SLOTS];
  logic [31:0]       per_q   [SLOTS];
  logic [SLOTS-1:0]  due_q;

  state_e     state_q;
  pass_e      pass_q;
  in_word_t   cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic       first_q;
  logic [15:0] min_delay_q;

  // running best of the current pass
  logic       best_found_q;
  logic [47:0] best_dl_q;
  logic [15:0] best_id_q;
  logic [31:0] best_per_q;
  logic [IDX_W-1:0] best_idx_q;

  // add / cancel bookkeeping
  logic       dup_q;
  logic       free_found_q;
  logic [IDX_W-1:0] free_idx_q;
  logic [1:0] stat_q;
  logic       changed_q;

  logic      out_valid_q;
  out_word_t out_q;

  // current slot under the scan pointer
  logic        s_v;
  logic [15:0] s_id;
  logic [47:0] s_dl;
  logic [31:0] s_per;
  logic        s_due;
  logic        s_id_hit;
  logic        cand;
  logic        key_lt;
  logic        idx_last;
  logic [48:0] rearm_sum;
  logic [47:0] rearm_dl;
  logic [48:0] delay_diff;
  logic [47:0] delay_raw;
  logic [47:0] delay_fin;

  assign s_v      = valid_q[idx_q];
  assign s_id     = id_q[idx_q];
  assign s_dl     = dl_q[idx_q];
  assign s_per    = per_q[idx_q];
  assign s_due    = s_v && (s_dl <= cmd_q.now);
  assign s_id_hit = s_v && (s_id == cmd_q.timer_id);
  assign idx_last = (idx_q == IDX_W'(SLOTS - 1));

  tqe_key_cmp u_cmp (
    .a_i  ('{deadline: s_dl, timer_id: s_id}),
    .b_i  ('{deadline: best_dl_q, timer_id: best_id_q}),
    .lt_o (key_lt)
  );

  // which slots compete for the minimum in this pass
  always_comb begin
    unique case (pass_q)
      PS_PICK:   cand = first_q ? s_due : (due_q[idx_q] && s_v);
      PS_CANCEL: cand = 1'b0;
      default:   cand = s_v;
    endcase
  end

  // re-arm saturates at the top of the 48-bit range
  assign rearm_sum = {1'b0, best_dl_q} + {17'd0, best_per_q};
  assign rearm_dl  = rearm_sum[48] ? {48{1'b1}} : rearm_sum[47:0];

  // delay to next expiry, zero once passed, floored at min_delay
  assign delay_diff = {1'b0, best_dl_q} - {1'b0, cmd_q.now};
  assign delay_raw  = delay_diff[48] ? 48'd0 : delay_diff[47:0];
  assign delay_fin  = (delay_raw < {32'd0, min_delay_q}) ? {32'd0, min_delay_q} : delay_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pass_q       <= PS_STAT;
      first_q      <= 1'b0;
      idx_q        <= '0;
      best_found_q <= 1'b0;
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      min_delay_q  <= MIN_DELAY_RST;
      due_q        <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        min_delay_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q        <= in_word_i;
            stat_q       <= STAT_OK;
            changed_q    <= 1'b0;
            dup_q        <= 1'b0;
            free_found_q <= 1'b0;
            best_found_q <= 1'b0;
            idx_q        <= '0;
            first_q      <= 1'b1;
            state_q      <= ST_SCAN;
            unique case (in_word_i.kind)
              KIND_ADD:    pass_q <= PS_ADD;
              KIND_CANCEL: pass_q <= PS_CANCEL;
              KIND_TICK:   pass_q <= PS_PICK;
              default:     pass_q <= PS_STAT;
            endcase
          end
        end
        ST_SCAN: begin
          if (cand && (!best_found_q || key_lt)) begin
            best_found_q <= 1'b1;
            best_dl_q    <= s_dl;
            best_id_q    <= s_id;
            best_per_q   <= s_per;
            best_idx_q   <= idx_q;
          end
          if (pass_q == PS_ADD) begin
            if (s_id_hit) begin
              dup_q <= 1'b1;
            end
            if (!s_v && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= idx_q;
            end
          end
          // cancel: first matching slot, held in the free slot index
          if (pass_q == PS_CANCEL && s_id_hit && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          if (pass_q == PS_PICK && first_q) begin
            due_q[idx_q] <= s_due;
          end
          if (idx_last) begin
            state_q <= ST_POST;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_POST: begin
          // default next step: final status pass
          idx_q        <= '0;
          best_found_q <= 1'b0;
          state_q      <= ST_SCAN;
          unique case (pass_q)
            PS_ADD: begin
              pass_q <= PS_STAT;
              if (dup_q) begin
                stat_q <= STAT_DUP;
              end else if (!free_found_q) begin
                stat_q <= STAT_FULL;
              end else begin
                valid_q[free_idx_q] <= 1'b1;
                id_q[free_idx_q]    <= cmd_q.timer_id;
                dl_q[free_idx_q]    <= cmd_q.deadline;
                per_q[free_idx_q]   <= cmd_q.interval;
                changed_q <= !best_found_q || (cmd_q.deadline < best_dl_q);
              end
            end
            PS_CANCEL: begin
              pass_q <= PS_STAT;
              if (free_found_q) begin
                valid_q[free_idx_q] <= 1'b0;
              end
            end
            PS_PICK: begin
              if (!best_found_q) begin
                pass_q <= PS_STAT;
              end else begin
                // fire the earliest due timer, then re-arm or retire it
                due_q[best_idx_q] <= 1'b0;
                if (best_per_q != 32'd0) begin
                  dl_q[best_idx_q] <= rearm_dl;
                end else begin
                  valid_q[best_idx_q] <= 1'b0;
                end
                out_q       <= '{is_fire: 1'b1, fired_id: best_id_q, status: STAT_OK,
                                 earliest_changed: 1'b0, next_valid: 1'b0,
                                 next_deadline: 48'd0, next_delay: 48'd0, last: 1'b0};
                out_valid_q <= 1'b1;
                state_q     <= ST_FIRE;
              end
            end
            PS_STAT: begin
              out_q       <= '{is_fire: 1'b0, fired_id: 16'd0, status: stat_q,
                               earliest_changed: changed_q, next_valid: best_found_q,
                               next_deadline: best_found_q ? best_dl_q : 48'd0,
                               next_delay: best_found_q ? delay_fin : 48'd0, last: 1'b1};
              out_valid_q <= 1'b1;
              state_q     <= ST_STAT;
            end
            default: begin
              pass_q <= PS_STAT;
            end
          endcase
        end
        ST_FIRE: begin
          if (!out_stall_i) begin
            out_valid_q  <= 1'b0;
            pass_q       <= PS_PICK;
            first_q      <= 1'b0;
            idx_q        <= '0;
            best_found_q <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_STAT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[rtl/core/tqe_key_cmp.sv]
// shared ordering comparator on (deadline, id) keys
module tqe_key_cmp
  import tqe_pkg::*;
(
  input  key_t a_i,
  input  key_t b_i,
  output logic lt_o
);

  assign lt_o = (a_i.deadline < b_i.deadline) ||
                ((a_i.deadline == b_i.deadline) && (a_i.timer_id < b_i.timer_id));

endmodule

[tb/testbench.sv]
// self-checking testbench for the timer queue expiry unit
module testbench;
  import tqe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RAND_ITEMS  = 204;
  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic      cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  timer_queue_expiry_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the timer table, kept in step with accepted words
  logic        tbl_armed [SLOTS];
  logic [15:0] tbl_id    [SLOTS];
  logic [47:0] tbl_dl    [SLOTS];
  logic [31:0] tbl_per   [SLOTS];
  logic [15:0] min_delay = MIN_DELAY_RST;

  // result words still owed by the block, oldest first
  out_word_t pending_words[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [47:0] clock_now = 48'd1000;

  // earliest armed deadline, returns 0 when the table is empty
  function automatic logic earliest_armed(output logic [47:0] dl);
    logic found;
    found = 1'b0;
    dl = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_armed[i] && (!found || tbl_dl[i] < dl)) begin
        dl = tbl_dl[i];
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic out_word_t status_word(logic [1:0] stat, logic changed,
                                            logic [47:0] now);
    out_word_t w;
    logic [47:0] dl;
    logic [47:0] gap;
    w = '0;
    w.status = stat;
    w.earliest_changed = changed;
    w.last = 1'b1;
    w.next_valid = earliest_armed(dl);
    if (w.next_valid) begin
      gap = (dl > now) ? dl - now : 48'd0;
      if (gap < {32'd0, min_delay}) gap = {32'd0, min_delay};
      w.next_deadline = dl;
      w.next_delay = gap;
    end
    return w;
  endfunction

  // apply one command to the shadow table and queue the words it yields
  function automatic void advance_timer_table(in_word_t cmd);
    int free_slot;
    int pick;
    logic dup;
    logic any;
    logic [47:0] cur;
    logic [48:0] sum;
    logic due [SLOTS];
    out_word_t fw;
    free_slot = -1;
    dup = 1'b0;
    case (cmd.kind)
      KIND_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_armed[i] && tbl_id[i] == cmd.timer_id) dup = 1'b1;
          if (!tbl_armed[i] && free_slot < 0) free_slot = i;
        end
        if (dup) begin
          pending_words.push_back(status_word(STAT_DUP, 1'b0, cmd.now));
        end else if (free_slot < 0) begin
          pending_words.push_back(status_word(STAT_FULL, 1'b0, cmd.now));
        end else begin
          any = earliest_armed(cur);
          tbl_armed[free_slot] = 1'b1;
          tbl_id[free_slot] = cmd.timer_id;
          tbl_dl[free_slot] = cmd.deadline;
          tbl_per[free_slot] = cmd.interval;
          pending_words.push_back(status_word(STAT_OK, !any || cmd.deadline < cur,
                                              cmd.now));
        end
      end
      KIND_CANCEL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!dup && tbl_armed[i] && tbl_id[i] == cmd.timer_id) begin
            tbl_armed[i] = 1'b0;
            dup = 1'b1;
          end
        end
        pending_words.push_back(status_word(STAT_OK, 1'b0, cmd.now));
      end
      KIND_TICK: begin
        // due set is frozen up front so a re-armed timer cannot fire twice
        for (int i = 0; i < SLOTS; i++) due[i] = tbl_armed[i] && tbl_dl[i] <= cmd.now;
        forever begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (due[i] && (pick < 0 || tbl_dl[i] < tbl_dl[pick] ||
                (tbl_dl[i] == tbl_dl[pick] && tbl_id[i] < tbl_id[pick])))
              pick = i;
          end
          if (pick < 0) break;
          due[pick] = 1'b0;
          fw = '0;
          fw.is_fire = 1'b1;
          fw.fired_id = tbl_id[pick];
          pending_words.push_back(fw);
          if (tbl_per[pick] != 0) begin
            sum = {1'b0, tbl_dl[pick]} + {17'd0, tbl_per[pick]};
            tbl_dl[pick] = sum[48] ? T_MAX : sum[47:0];
          end else begin
            tbl_armed[pick] = 1'b0;
          end
        end
        pending_words.push_back(status_word(STAT_OK, 1'b0, cmd.now));
      end
      default: begin
        pending_words.push_back(status_word(STAT_OK, 1'b0, cmd.now));
      end
    endcase
  endfunction

  // result side: check taken words, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected word %h", out_word_o);
      end else begin
        want = pending_words.pop_front();
        if (out_word_o.is_fire !== want.is_fire ||
            out_word_o.fired_id !== want.fired_id ||
            out_word_o.status !== want.status ||
            out_word_o.earliest_changed !== want.earliest_changed ||
            out_word_o.next_valid !== want.next_valid ||
            out_word_o.next_deadline !== want.next_deadline ||
            out_word_o.next_delay !== want.next_delay ||
            out_word_o.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: fire %b/%b id %h/%h st %0d/%0d chg %b/%b nv %b/%b dl %h/%h dly %h/%h last %b/%b",
                     want.is_fire, out_word_o.is_fire, want.fired_id, out_word_o.fired_id,
                     want.status, out_word_o.status, want.earliest_changed,
                     out_word_o.earliest_changed, want.next_valid, out_word_o.next_valid,
                     want.next_deadline, out_word_o.next_deadline, want.next_delay,
                     out_word_o.next_delay, want.last, out_word_o.last);
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // present one word and wait until taken; valid stays up between words bar idle gaps
  task automatic send_word(in_word_t w);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_timer_table(w);
  endtask

  // let every owed word come back, then wait with the input idle
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_min_delay(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    min_delay = v;
    @(posedge clk_i);
  endtask

  function automatic in_word_t make_cmd(logic [1:0] kind, logic [15:0] id,
                                        logic [47:0] dl, logic [31:0] per,
                                        logic [47:0] now);
    in_word_t w;
    w.kind = kind;
    w.timer_id = id;
    w.deadline = dl;
    w.interval = per;
    w.now = now;
    return w;
  endfunction

  // random command: ids mostly from a small pool so duplicates and cancels hit
  function automatic in_word_t random_cmd();
    in_word_t w;
    int unsigned sel;
    w.kind = KIND_ADD;
    w.timer_id = 16'($urandom);
    w.deadline = 48'({$urandom, $urandom});
    w.interval = $urandom;
    w.now = 48'({$urandom, $urandom});
    sel = $urandom_range(0, 99);
    if (sel < 45) w.kind = KIND_ADD;
    else if (sel < 65) w.kind = KIND_CANCEL;
    else if (sel < 95) w.kind = KIND_TICK;
    else w.kind = KIND_UNUSED;
    if ($urandom_range(0, 9) != 0) w.timer_id = 16'($urandom_range(0, 23));
    if ($urandom_range(0, 19) != 0) begin
      w.deadline = clock_now + 48'($urandom_range(0, 5000));
      case ($urandom_range(0, 3))
        0, 1: w.interval = '0;
        2: w.interval = $urandom_range(1, 2000);
        default: ;
      endcase
      if (w.kind == KIND_TICK) clock_now = clock_now + 48'($urandom_range(0, 3000));
      w.now = clock_now;
    end
    return w;
  endfunction

  typedef struct {
    in_word_t    cmd;
    logic        chk;
    logic [1:0]  stat;
  } dir_row_t;

  dir_row_t dir_rows[10];

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_armed[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_dl[i] = '0;
      tbl_per[i] = '0;
    end
    // extremes of the fields, duplicate, unknown cancel, saturating re-arm, unused kind
    dir_rows[0] = '{make_cmd(KIND_TICK, 16'h0000, '0, '0, '0), 1'b1, STAT_OK};
    dir_rows[1] = '{make_cmd(KIND_ADD, 16'h0000, '0, 32'hFFFF_FFFF, '0), 1'b1, STAT_OK};
    dir_rows[2] = '{make_cmd(KIND_ADD, 16'hFFFF, T_MAX, '0, T_MAX), 1'b1, STAT_OK};
    dir_rows[3] = '{make_cmd(KIND_ADD, 16'h0000, 48'd5, 32'd3, 48'd2), 1'b1, STAT_DUP};
    dir_rows[4] = '{make_cmd(KIND_CANCEL, 16'h1234, '0, '0, 48'd10), 1'b1, STAT_OK};
    dir_rows[5] = '{make_cmd(KIND_ADD, 16'h0007, 48'hFFFF_FFFF_FFF0, 32'hFFFF_FFFF, '0),
                    1'b1, STAT_OK};
    dir_rows[6] = '{make_cmd(KIND_TICK, '0, '0, '0, T_MAX), 1'b1, STAT_OK};
    dir_rows[7] = '{make_cmd(KIND_UNUSED, 16'hFFFF, T_MAX, 32'hFFFF_FFFF, T_MAX),
                    1'b1, STAT_OK};
    dir_rows[8] = '{make_cmd(KIND_CANCEL, 16'h0000, '0, '0, 48'd50), 1'b1, STAT_OK};
    dir_rows[9] = '{make_cmd(KIND_CANCEL, 16'h0007, '0, '0, 48'd50), 1'b1, STAT_OK};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset value of the minimum delay
    foreach (dir_rows[r]) begin
      send_word(dir_rows[r].cmd);
      if (dir_rows[r].chk && pending_words[$].status !== dir_rows[r].stat) begin
        fail_count++;
        if (fail_count <= 10) $display("row %0d: status %0d, table says %0d",
                                       r, pending_words[$].status, dir_rows[r].stat);
      end
    end
    // fill every slot, one more add is refused, then one tick fires them all
    for (int i = 0; i <= SLOTS; i++)
      send_word(make_cmd(KIND_ADD, 16'(100 + i), 48'(1000 + i % 3), '0, 48'd900));
    if (pending_words[$].status !== STAT_FULL) begin
      fail_count++;
      if (fail_count <= 10) $display("full table not flagged by the shadow table");
    end
    send_word(make_cmd(KIND_TICK, '0, '0, '0, 48'd2000));
    drain();

    // random part in three idling phases, each with its own minimum delay
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 45;
          write_min_delay(16'hFFFF);
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 21;
          write_min_delay(16'h0000);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_min_delay(16'($urandom));
        end
      endcase
      for (int n = 0; n < RAND_ITEMS / 3; n++) send_word(random_cmd());
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/tqe_pkg.sv
rtl/core/tqe_key_cmp.sv
rtl/core/timer_queue_expiry_unit.sv
tb/testbench.sv
